@@ rtl/nse_pkg.sv @@
// -----------------------------------------------------------------------------
// nse_pkg
// Character codes, flag record and byte filter for the NMEA sentence extractor.
// -----------------------------------------------------------------------------
package nse_pkg;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] PRINT_LO  = 8'h20;
   localparam logic [7:0] PRINT_HI  = 8'h7E;

   // Most bytes one request can produce: LF, '$', 'G', closing LF.
   localparam int unsigned BURST_MAX = 4;

   typedef struct packed {
      logic pending_dollar;
      logic line_open;
      logic star_seen;
      logic first_check_seen;
      logic second_check_seen;
      logic ended_with_lf;
   } flags_type;

   // CR goes out as LF.
   function automatic logic [7:0] map_char(input logic [7:0] b);
      logic [7:0] r;
      r = (b == CH_CR) ? CH_LF : b;
      return r;
   endfunction

   // Printable (0x21..0x7E) or LF; anything else is dropped.
   function automatic logic keep_char(input logic [7:0] b);
      logic k;
      k = ((b > PRINT_LO) && (b <= PRINT_HI)) || (b == CH_LF);
      return k;
   endfunction

endpackage

@@ rtl/nmea_sentence_extractor_unit.sv @@
// -----------------------------------------------------------------------------
// nmea_sentence_extractor_unit
// Filters a raw GNSS byte stream down to "$G" NMEA sentences, one LF per line.
// -----------------------------------------------------------------------------
// Output: the first byte of a request's output is valid in the cycle after accept.
// Throughput: one request per cycle while each makes at most one byte and
//   rsp_tready is high; a request that makes more bytes (at most 4) blocks
//   new requests until the single-byte output port drains the result buffer.
// Reset: synchronous, active high; clears all sentence flags and buffer count/index.
module nmea_sentence_extractor_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_buffer
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // run_last
);

   localparam int unsigned IDX_W = $clog2(nse_pkg::BURST_MAX);
   localparam int unsigned CNT_W = $clog2(nse_pkg::BURST_MAX + 1);

   nse_pkg::flags_type flags_ff, flags_in;

   logic [7:0]       burst_byte_ff [nse_pkg::BURST_MAX];
   logic [7:0]       burst_byte_in [nse_pkg::BURST_MAX];
   logic [CNT_W-1:0] burst_cnt_ff, burst_cnt_in;
   logic [IDX_W-1:0] burst_idx_ff, burst_idx_in;

   logic             accept;
   logic             pop;
   logic             pop_last;
   logic [CNT_W-1:0] n;
   logic [7:0]       c;
   logic [7:0]       cm;
   logic             restart;

   assign pop      = rsp_tvalid && rsp_tready;
   assign pop_last = (burst_idx_ff == IDX_W'(burst_cnt_ff - CNT_W'(1)));
   assign req_tready = (burst_cnt_ff == '0) || (pop && pop_last);
   assign accept   = req_tvalid && req_tready;

   assign rsp_tvalid = (burst_cnt_ff != '0);
   assign rsp_tdata  = burst_byte_ff[burst_idx_ff];
   assign rsp_tlast  = pop_last;

   assign c  = req_tdata;
   assign cm = nse_pkg::map_char(req_tdata);

   // Sentence decode for one request; output bytes are packed in order.
   always_comb begin
      flags_in = flags_ff;
      n        = '0;
      for (int i = 0; i < nse_pkg::BURST_MAX; i++) begin
         burst_byte_in[i] = nse_pkg::CH_LF;
      end

      restart = flags_ff.pending_dollar && (c == nse_pkg::CH_G);
      flags_in.pending_dollar = 1'b0;

      if (restart) begin
         if (flags_ff.line_open) begin
            burst_byte_in[n[IDX_W-1:0]] = nse_pkg::CH_LF;
            n = n + CNT_W'(1);
         end
         burst_byte_in[n[IDX_W-1:0]] = nse_pkg::CH_DOLLAR;
         n = n + CNT_W'(1);
         burst_byte_in[n[IDX_W-1:0]] = nse_pkg::CH_G;
         n = n + CNT_W'(1);
         flags_in.line_open         = 1'b1;
         flags_in.star_seen         = 1'b0;
         flags_in.first_check_seen  = 1'b0;
         flags_in.second_check_seen = 1'b0;
         flags_in.ended_with_lf     = 1'b0;
      end else if (c == nse_pkg::CH_DOLLAR) begin
         flags_in.pending_dollar = 1'b1;
      end else if (!flags_ff.star_seen && c == nse_pkg::CH_STAR && flags_ff.line_open) begin
         flags_in.star_seen = 1'b1;
         burst_byte_in[n[IDX_W-1:0]] = c;
         n = n + CNT_W'(1);
         flags_in.ended_with_lf = 1'b0;
      end else if (flags_ff.second_check_seen) begin
         burst_byte_in[n[IDX_W-1:0]] = nse_pkg::CH_LF;
         n = n + CNT_W'(1);
         flags_in.ended_with_lf     = 1'b1;
         flags_in.line_open         = 1'b0;
         flags_in.star_seen         = 1'b0;
         flags_in.first_check_seen  = 1'b0;
         flags_in.second_check_seen = 1'b0;
      end else if ((flags_ff.star_seen && !flags_ff.first_check_seen)
                   || (flags_ff.first_check_seen && !flags_ff.second_check_seen)
                   || flags_ff.line_open) begin
         if (flags_ff.star_seen && !flags_ff.first_check_seen) begin
            flags_in.first_check_seen = 1'b1;
         end else if (flags_ff.first_check_seen && !flags_ff.second_check_seen) begin
            flags_in.second_check_seen = 1'b1;
         end
         if (nse_pkg::keep_char(cm)) begin
            burst_byte_in[n[IDX_W-1:0]] = cm;
            n = n + CNT_W'(1);
            flags_in.ended_with_lf = (cm == nse_pkg::CH_LF);
         end
      end

      if (req_tlast) begin
         flags_in.pending_dollar = 1'b0;
         if (!flags_in.ended_with_lf) begin
            burst_byte_in[n[IDX_W-1:0]] = nse_pkg::CH_LF;
            n = n + CNT_W'(1);
            flags_in.ended_with_lf = 1'b1;
         end
         flags_in.line_open         = 1'b0;
         flags_in.star_seen         = 1'b0;
         flags_in.first_check_seen  = 1'b0;
         flags_in.second_check_seen = 1'b0;
      end
   end

   always_comb begin
      burst_cnt_in = burst_cnt_ff;
      burst_idx_in = burst_idx_ff;
      if (accept) begin
         burst_cnt_in = n;
         burst_idx_in = '0;
      end else if (pop) begin
         if (pop_last) begin
            burst_cnt_in = '0;
         end else begin
            burst_idx_in = burst_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         burst_cnt_ff <= '0;
         burst_idx_ff <= '0;
      end else begin
         if (accept) begin
            flags_ff <= flags_in;
         end
         burst_cnt_ff <= burst_cnt_in;
         burst_idx_ff <= burst_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < nse_pkg::BURST_MAX; i++) begin
            burst_byte_ff[i] <= burst_byte_in[i];
         end
      end
   end

endmodule
